FILE: src/kt_pkg.sv
// keyword tokenizer package: lexer modes, token kinds, result bundle type
// no dependencies
`default_nettype none
package kt_pkg;

    typedef enum logic [3:0] {
        M_IDLE      = 4'd0,
        M_IDENT     = 4'd1,
        M_NUM       = 4'd2,
        M_COMMENT   = 4'd3,
        M_STR_OPEN  = 4'd4,
        M_STR       = 4'd5,
        M_STR_ESC   = 4'd6,
        M_CHR_OPEN  = 4'd7,
        M_CHR_ESC   = 4'd8,
        M_CHR_CLOSE = 4'd9
    } t_mode;

    localparam logic [4:0] K_PIECE  = 5'd0;
    localparam logic [4:0] K_IDENT  = 5'd1;
    localparam logic [4:0] K_NUMBER = 5'd2;
    localparam logic [4:0] K_STRING = 5'd3;
    localparam logic [4:0] K_SINGLE = 5'd4;
    localparam logic [4:0] K_END    = 5'd5;

    localparam logic [7:0] CONTROL_LIMIT = 8'd32;
    localparam int         MAX_RES       = 4;
    localparam int         KW_COUNT      = 23;
    localparam int         KW_MAX_LEN    = 8;

    typedef struct packed {
        logic [4:0]  kind;
        logic [7:0]  text_byte;
        logic [15:0] line;
        logic        last_of_run;
    } t_res;

    // one input byte's worth of results, slots filled from zero
    typedef struct packed {
        logic [2:0]         count;
        t_res [MAX_RES-1:0] res;
    } t_bundle;

    function automatic logic [7:0] kw_char(input int k, input int p);
        string s;
        case (k)
            0: s = "program";   1: s = "com";      2: s = "llreturn";
            3: s = "add";       4: s = "sub";      5: s = "and";
            6: s = "or";        7: s = "xor";      8: s = "COMPARE";
            9: s = "if";        10: s = "else";    11: s = "return";
            12: s = "func";     13: s = "funky";   14: s = "comstore";
            15: s = "mem";      16: s = "loadmem"; 17: s = "memstore";
            18: s = "intcast";  19: s = "to";      20: s = "block";
            21: s = "goto";     default: s = "exported";
        endcase
        if (p < s.len()) kw_char = s[p];
        else kw_char = 8'd0;
    endfunction

    function automatic logic [3:0] kw_len(input int k);
        case (k)
            0, 8, 16, 18: kw_len = 4'd7;
            2, 14, 17, 22: kw_len = 4'd8;
            6, 9, 19: kw_len = 4'd2;
            10, 12, 21: kw_len = 4'd4;
            11: kw_len = 4'd6;
            13, 20: kw_len = 4'd5;
            default: kw_len = 4'd3;
        endcase
    endfunction

    function automatic logic [4:0] kw_kind(input int k);
        if (k <= 12) kw_kind = 5'(k + 6);
        else kw_kind = 5'(k + 5);
    endfunction

endpackage
`default_nettype wire

FILE: src/kt_front.sv
// front end: accepts bytes, runs the lexer state and builds result bundles
// depends on kt_pkg
`default_nettype none
module kt_front #(
    parameter int KEYWORD_CHARS = 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_take,
    input  wire logic [7:0]       i_ch,
    input  wire logic             i_end_of_input,
    output kt_pkg::t_bundle       o_bundle
);
    localparam int LW = $clog2(KEYWORD_CHARS + 2);
    localparam int IW = $clog2(KEYWORD_CHARS);

    kt_pkg::t_mode r_mode, n_mode;
    logic [7:0]    r_buf [KEYWORD_CHARS];
    logic [LW-1:0] r_len, n_len;
    logic [15:0]   r_line, n_line;
    logic          add_en;
    logic [7:0]    add_b;

    // keyword match over the buffer
    logic [4:0] idkind;
    always_comb begin
        logic hit;
        idkind = kt_pkg::K_IDENT;
        for (int k = kt_pkg::KW_COUNT - 1; k >= 0; k--) begin
            hit = (r_len == LW'(kt_pkg::kw_len(k)));
            for (int p = 0; p < kt_pkg::KW_MAX_LEN; p++) begin
                if (p < KEYWORD_CHARS && p < int'(kt_pkg::kw_len(k))) begin
                    if (r_buf[p] != kt_pkg::kw_char(k, p)) hit = 1'b0;
                end
            end
            if (hit) idkind = kt_pkg::kw_kind(k);
        end
    end

    function automatic logic is_space(input logic [7:0] b);
        return b == 8'd32 || (b >= 8'd9 && b <= 8'd13);
    endfunction
    function automatic logic is_alpha(input logic [7:0] b);
        return (b >= 8'd97 && b <= 8'd122) || (b >= 8'd65 && b <= 8'd90);
    endfunction
    function automatic logic is_digit(input logic [7:0] b);
        return b >= 8'd48 && b <= 8'd57;
    endfunction
    function automatic logic [7:0] unesc(input logic [7:0] b);
        case (b)
            8'd110:  return 8'd10;
            8'd114:  return 8'd13;
            8'd116:  return 8'd9;
            8'd48:   return 8'd0;
            default: return b;
        endcase
    endfunction

    kt_pkg::t_bundle bun;

    function automatic void push(input logic [4:0] k, input logic [7:0] t);
        if (bun.count < 3'(kt_pkg::MAX_RES)) begin
            bun.res[bun.count[1:0]].kind      = k;
            bun.res[bun.count[1:0]].text_byte = t;
            bun.count = bun.count + 3'd1;
        end
    endfunction

    // decimal digits of a byte via small multiply by reciprocal
    function automatic void code_out(input logic [7:0] c);
        logic [15:0] m100;
        logic [15:0] m10;
        logic [3:0]  d100;
        logic [3:0]  d10;
        logic [3:0]  d1;
        logic [7:0]  rem100;
        m100   = 16'(c) * 16'd41;
        d100   = 4'(m100 >> 12);
        rem100 = c - 8'(d100) * 8'd100;
        m10    = 16'(rem100) * 16'd205;
        d10    = 4'(m10 >> 11);
        d1     = 4'(rem100 - 8'(d10) * 8'd10);
        if (c >= 8'd100) push(kt_pkg::K_PIECE, 8'd48 + 8'(d100));
        if (c >= 8'd10) push(kt_pkg::K_PIECE, 8'd48 + 8'(d10));
        push(kt_pkg::K_PIECE, 8'd48 + 8'(d1));
        push(kt_pkg::K_NUMBER, 8'd0);
    endfunction

    always_comb begin
        logic [7:0] b;
        logic       st;
        logic [7:0] sb;
        logic       cc;
        logic [7:0] cd;
        b       = i_ch;
        bun     = '0;
        n_mode  = r_mode;
        n_len   = r_len;
        n_line  = r_line;
        add_en  = 1'b0;
        add_b   = b;
        st      = 1'b0;
        sb      = b;
        cc      = 1'b0;
        cd      = b;
        if (i_end_of_input) begin
            case (r_mode)
                kt_pkg::M_IDENT: push(idkind, 8'd0);
                kt_pkg::M_NUM: push(kt_pkg::K_NUMBER, 8'd0);
                kt_pkg::M_STR_OPEN, kt_pkg::M_STR: push(kt_pkg::K_STRING, 8'd0);
                kt_pkg::M_STR_ESC: begin
                    push(kt_pkg::K_PIECE, 8'd0);
                    push(kt_pkg::K_STRING, 8'd0);
                end
                kt_pkg::M_CHR_OPEN, kt_pkg::M_CHR_ESC: begin
                    cd = 8'd0;
                    cc = 1'b1;
                end
                default: ;
            endcase
            if (cc) code_out(cd);
            push(kt_pkg::K_END, 8'd0);
            n_mode = kt_pkg::M_IDLE;
            n_len  = '0;
            n_line = 16'd1;
        end else begin
            if (b == 8'd10 && r_line != 16'hFFFF) n_line = r_line + 16'd1;
            case (r_mode)
                kt_pkg::M_IDENT: begin
                    if (is_alpha(b) || is_digit(b) || b == 8'd95) begin
                        add_en = 1'b1;
                        push(kt_pkg::K_PIECE, b);
                    end else begin
                        push(idkind, 8'd0);
                        st = 1'b1;
                    end
                end
                kt_pkg::M_NUM: begin
                    if (is_digit(b) || b == 8'd46 || b == 8'd102)
                        push(kt_pkg::K_PIECE, b);
                    else if (b != 8'd95) begin
                        push(kt_pkg::K_NUMBER, 8'd0);
                        st = 1'b1;
                    end
                end
                kt_pkg::M_COMMENT: begin
                    if (b == 8'd10 || b == 8'd13) n_mode = kt_pkg::M_IDLE;
                end
                kt_pkg::M_STR_OPEN, kt_pkg::M_STR: begin
                    if (b == 8'd34) begin
                        push(kt_pkg::K_STRING, 8'd0);
                        n_mode = kt_pkg::M_IDLE;
                    end else if (r_mode == kt_pkg::M_STR && b < kt_pkg::CONTROL_LIMIT) begin
                        push(kt_pkg::K_STRING, 8'd0);
                        st = 1'b1;
                    end else if (b == 8'd92) begin
                        n_mode = kt_pkg::M_STR_ESC;
                    end else begin
                        push(kt_pkg::K_PIECE, b);
                        n_mode = kt_pkg::M_STR;
                    end
                end
                kt_pkg::M_STR_ESC: begin
                    push(kt_pkg::K_PIECE, unesc(b));
                    n_mode = kt_pkg::M_STR;
                end
                kt_pkg::M_CHR_OPEN: begin
                    if (b == 8'd92) n_mode = kt_pkg::M_CHR_ESC;
                    else begin
                        cc = 1'b1;
                        n_mode = kt_pkg::M_CHR_CLOSE;
                    end
                end
                kt_pkg::M_CHR_ESC: begin
                    cd = unesc(b);
                    cc = 1'b1;
                    n_mode = kt_pkg::M_CHR_CLOSE;
                end
                kt_pkg::M_CHR_CLOSE: begin
                    if (b == 8'd39) n_mode = kt_pkg::M_IDLE;
                    else st = 1'b1;
                end
                default: st = 1'b1;
            endcase
            if (cc) code_out(cd);
            if (st) begin
                n_mode = kt_pkg::M_IDLE;
                if (is_space(sb)) begin
                end else if (is_alpha(sb)) begin
                    n_mode = kt_pkg::M_IDENT;
                    n_len  = '0;
                    add_en = 1'b1;
                    push(kt_pkg::K_PIECE, sb);
                end else if (is_digit(sb)) begin
                    n_mode = kt_pkg::M_NUM;
                    push(kt_pkg::K_PIECE, sb);
                end else if (sb == 8'd39) n_mode = kt_pkg::M_CHR_OPEN;
                else if (sb == 8'd34) n_mode = kt_pkg::M_STR_OPEN;
                else if (sb == 8'd35) n_mode = kt_pkg::M_COMMENT;
                else if (sb < kt_pkg::CONTROL_LIMIT) push(kt_pkg::K_END, 8'd0);
                else push(kt_pkg::K_SINGLE, sb);
            end
            if (add_en) begin
                if (st) n_len = LW'(1);
                else if (r_len <= LW'(KEYWORD_CHARS)) n_len = r_len + LW'(1);
            end
        end
        for (int i = 0; i < kt_pkg::MAX_RES; i++) begin
            bun.res[i].line = i_end_of_input ? r_line : n_line;
            bun.res[i].last_of_run = (3'(i + 1) == bun.count);
        end
    end

    // buffer write position: restart at zero on a new identifier
    logic [LW-1:0] wpos;
    assign wpos = (n_mode == kt_pkg::M_IDENT && n_len == LW'(1)) ? '0 : r_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= kt_pkg::M_IDLE;
            r_len  <= '0;
            r_line <= 16'd1;
        end else if (i_take) begin
            r_mode <= n_mode;
            r_len  <= n_len;
            r_line <= n_line;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take && add_en && !i_end_of_input && wpos < LW'(KEYWORD_CHARS))
            r_buf[wpos[IW-1:0]] <= add_b;
    end

    assign o_bundle = bun;
endmodule
`default_nettype wire

FILE: src/kt_queue.sv
// bundle queue between front and back, with free-slot accounting
// depends on kt_pkg
`default_nettype none
module kt_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  kt_pkg::t_bundle      i_data,
    output logic                 o_full,
    input  wire logic            i_pop,
    output logic                 o_empty,
    output kt_pkg::t_bundle      o_data
);
    localparam int AW = $clog2(DEPTH);
    kt_pkg::t_bundle r_mem [DEPTH];
    logic [AW-1:0] r_wr, r_rd;
    logic [AW:0]   r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
            if (i_pop)  r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
            r_cnt <= r_cnt + (AW+1)'(i_push) - (AW+1)'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_data;
    end

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];
endmodule
`default_nettype wire

FILE: src/kt_back.sv
// back end: slots to the output register, one word per cycle unless stalled
// depends on kt_pkg
`default_nettype none
module kt_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_empty,
    input  kt_pkg::t_bundle      i_data,
    output logic                 o_pop,
    input  wire logic            i_stall,
    output logic                 o_valid,
    output kt_pkg::t_res         o_res
);
    logic [1:0]   r_slot;
    logic         r_valid;
    kt_pkg::t_res r_res;
    logic         load;

    assign load  = !i_empty && (!r_valid || !i_stall);
    assign o_pop = load && (3'(r_slot) + 3'd1 >= i_data.count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot  <= '0;
            r_valid <= 1'b0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_slot  <= o_pop ? 2'd0 : r_slot + 2'd1;
            end else if (!i_stall) r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) r_res <= i_data.res[r_slot];
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;
endmodule
`default_nettype wire

FILE: src/keyword_tokenizer_top.sv
// keyword tokenizer top: front lexer, bundle queue, result back end
// depends on kt_pkg, kt_front, kt_queue, kt_back
//
// input channel: i_valid/o_stall with i_ch and i_end_of_input, one byte per word
// output channel: o_valid/i_stall with kind, text_byte, line, last_of_run
// each input byte makes zero to four result words; a byte is taken every cycle
// while the queue has room (QUEUE_DEPTH bundles), so throughput is one byte per
// cycle and one result word per cycle on the output while i_stall is low
// an accepted byte's results pass through a queue slot, then the output register
// bytes that make no result pass through the front alone and leave no word
// sustained input rate falls below one byte per cycle only while results
// outnumber bytes or the receiver stalls, set by the single output register
// reset clears lexer mode, line count (to one), queue and output valid
// when the receiver stalls the output word holds, the queue fills, then o_stall
// rises
`default_nettype none
module keyword_tokenizer_top #(
    parameter int KEYWORD_CHARS = 8,
    parameter int QUEUE_DEPTH   = 4
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_ch,
    input  wire logic        i_end_of_input,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [4:0]       o_kind,
    output logic [7:0]       o_text_byte,
    output logic [15:0]      o_line,
    output logic             o_last_of_run
);
    kt_pkg::t_bundle bun, qd;
    kt_pkg::t_res    res;
    logic take, full, empty, pop;

    assign o_stall = full;
    assign take    = i_valid && !full;

    kt_front #(.KEYWORD_CHARS(KEYWORD_CHARS)) u_front (
        .i_clk, .i_rst_n, .i_take(take), .i_ch, .i_end_of_input, .o_bundle(bun)
    );

    kt_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk, .i_rst_n, .i_push(take && bun.count != 3'd0), .i_data(bun),
        .o_full(full), .i_pop(pop), .o_empty(empty), .o_data(qd)
    );

    kt_back u_back (
        .i_clk, .i_rst_n, .i_empty(empty), .i_data(qd), .o_pop(pop),
        .i_stall, .o_valid, .o_res(res)
    );

    assign o_kind        = res.kind;
    assign o_text_byte   = res.text_byte;
    assign o_line        = res.line;
    assign o_last_of_run = res.last_of_run;
endmodule
`default_nettype wire
